@@ rtl/core/dsre_pkg.sv @@
// shared types, constants and codes of the delta-stepping relax engine
package dsre_pkg;

  // table geometry
  localparam int VERTEX_COUNT = 1024;
  localparam int ADDR_W       = $clog2(VERTEX_COUNT);
  localparam int VERTEX_W     = 10;
  localparam int WEIGHT_W     = 16;
  localparam int DIST_W       = 31;
  localparam int PARENT_W     = 11;
  localparam int COUNT_W      = 11;
  localparam int DIV_CNT_W    = $clog2(DIST_W + 1);
  localparam int CFG_ADDR_W   = 3;

  // special values
  localparam logic [DIST_W-1:0]   UNREACHED   = {DIST_W{1'b1}};
  localparam logic [PARENT_W-1:0] PARENT_NONE = PARENT_W'(VERTEX_COUNT);
  localparam logic [COUNT_W-1:0]  PENDING_MAX = {COUNT_W{1'b1}};
  localparam logic [ADDR_W-1:0]   LAST_ADDR   = ADDR_W'(VERTEX_COUNT - 1);

  // item modes
  typedef enum logic [2:0] {
    MODE_START        = 3'd0,
    MODE_RELAX        = 3'd1,
    MODE_POP          = 3'd2,
    MODE_CLEAR_REPEAT = 3'd3,
    MODE_NEXT_BUCKET  = 3'd4,
    MODE_QUERY        = 3'd5
  } mode_t;

  // register index on the config port (byte address bit 2 and up)
  typedef enum logic [0:0] {
    REG_BUCKET_WIDTH = 1'b0
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_RD_A,
    ST_RD_B,
    ST_CMP,
    ST_DIV_WAIT,
    ST_POP_CHK,
    ST_QUERY_CAP,
    ST_DONE
  } state_t;

  // one vertex entry of the table memory
  typedef struct packed {
    logic [DIST_W-1:0]   path_len;
    logic [PARENT_W-1:0] parent;
    logic [DIST_W-1:0]   bucket;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{path_len: UNREACHED, parent: PARENT_NONE,
                                     bucket: UNREACHED};

  // table memory access
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  // divider start and answer
  typedef struct packed {
    logic              start;
    logic [DIST_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] quotient;
  } div_rsp_t;

  // one result item
  typedef struct packed {
    logic                improved;
    logic                popped;
    logic                repeat_flag;
    logic [COUNT_W-1:0]  pending_count;
    logic [DIST_W-1:0]   bucket_now;
    logic [DIST_W-1:0]   dist_out;
    logic [PARENT_W-1:0] parent_out;
  } res_t;

endpackage

@@ rtl/core/dsre_table_mem.sv @@
// per-vertex table memory: distance, parent and bucket in one word
module dsre_table_mem import dsre_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [VERTEX_COUNT];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/core/dsre_div.sv @@
// restoring divider, one quotient bit per cycle, for the bucket number
module dsre_div import dsre_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  input  logic [DIST_W-1:0] divisor,
  output div_rsp_t          rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIST_W-1:0]    quo;
  logic [DIST_W-1:0]    rem;
  logic [DIST_W-1:0]    dvs;
  logic [DIST_W:0]      trial;
  logic [DIST_W:0]      diff;
  logic                 fits;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[DIST_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIST_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath; a zero width divides as one
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= (divisor == '0) ? DIST_W'(1) : divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
      quo <= {quo[DIST_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ rtl/core/dsre_seq.sv @@
// sequencer: read-modify-write of the vertex tables and run status
module dsre_seq import dsre_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_take,
  input  mode_t               item_mode,
  input  logic [VERTEX_W-1:0] item_a,
  input  logic [VERTEX_W-1:0] item_b,
  input  logic [WEIGHT_W-1:0] item_w,
  output logic                busy,
  output mem_req_t            mem_req,
  input  entry_t              mem_rd,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp,
  output logic                res_valid,
  output res_t                res,
  input  logic                res_take
);

  state_t state, state_next;

  logic [ADDR_W-1:0]   clr_idx;
  logic                seed_pend;
  mode_t               mode_r;
  logic [VERTEX_W-1:0] a_r;
  logic [VERTEX_W-1:0] b_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [DIST_W:0]     nd_r;
  logic                improved_r;
  logic                popped_r;
  logic                b_fresh_r;
  logic [DIST_W-1:0]   dist_o_r;
  logic [PARENT_W-1:0] parent_o_r;

  logic [COUNT_W-1:0]  pending;
  logic [COUNT_W-1:0]  pending_next;
  logic                repeat_bit;
  logic                repeat_next;
  logic [DIST_W-1:0]   current_bucket;
  logic [DIST_W-1:0]   current_next;

  logic                pop_hit;
  logic                relax_win;
  logic                commit;

  // compares on the word just read
  always_comb begin
    pop_hit   = (mem_rd.bucket != UNREACHED) && (mem_rd.bucket == current_bucket);
    relax_win = {1'b0, mem_rd.path_len} > nd_r;
    commit    = (state == ST_DONE) && res_take;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_take) begin
          unique case (item_mode)
            MODE_START:                      state_next = ST_CLEAR;
            MODE_RELAX, MODE_POP, MODE_QUERY: state_next = ST_RD_A;
            default:                         state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_idx == LAST_ADDR) begin
          state_next = seed_pend ? ST_SEED : ST_IDLE;
        end
      end
      ST_SEED: state_next = ST_DONE;
      ST_RD_A: begin
        unique case (mode_r)
          MODE_RELAX: state_next = ST_RD_B;
          MODE_POP:   state_next = ST_POP_CHK;
          MODE_QUERY: state_next = ST_QUERY_CAP;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_RD_B:      state_next = ST_CMP;
      ST_CMP:       state_next = relax_win ? ST_DIV_WAIT : ST_DONE;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_POP_CHK:   state_next = ST_DONE;
      ST_QUERY_CAP: state_next = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory and divider drive
  always_comb begin
    mem_req          = '0;
    div_req.start    = 1'b0;
    div_req.dividend = nd_r[DIST_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_idx;
        mem_req.wr_data = RESET_ENTRY;
      end
      ST_SEED: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ADDR_W'(a_r);
        mem_req.wr_data = '{path_len: '0, parent: PARENT_W'(a_r), bucket: '0};
      end
      ST_RD_A: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = ADDR_W'(a_r);
      end
      ST_RD_B: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = ADDR_W'(b_r);
      end
      ST_CMP: begin
        div_req.start = relax_win;
      end
      ST_DIV_WAIT: begin
        mem_req.wr_en   = div_rsp.done;
        mem_req.wr_addr = ADDR_W'(b_r);
        mem_req.wr_data = '{path_len: nd_r[DIST_W-1:0], parent: PARENT_W'(a_r),
                            bucket: div_rsp.quotient};
      end
      ST_POP_CHK: begin
        mem_req.wr_en   = pop_hit;
        mem_req.wr_addr = ADDR_W'(a_r);
        mem_req.wr_data = '{path_len: mem_rd.path_len, parent: mem_rd.parent,
                            bucket: UNREACHED};
      end
      default: begin
      end
    endcase
  end

  // status after the item
  always_comb begin
    pending_next = pending;
    repeat_next  = repeat_bit;
    current_next = current_bucket;
    unique case (mode_r)
      MODE_START: begin
        pending_next = COUNT_W'(1);
        repeat_next  = 1'b1;
        current_next = '0;
      end
      MODE_RELAX: begin
        if (improved_r) begin
          if (b_fresh_r && (pending != PENDING_MAX)) begin
            pending_next = pending + 1'b1;
          end
          if (div_rsp.quotient == current_bucket) begin
            repeat_next = 1'b1;
          end
        end
      end
      MODE_POP: begin
        if (popped_r && (pending != '0)) begin
          pending_next = pending - 1'b1;
        end
      end
      MODE_CLEAR_REPEAT: repeat_next  = 1'b0;
      MODE_NEXT_BUCKET:  current_next = current_bucket + 1'b1;
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    busy              = (state != ST_IDLE);
    res_valid         = (state == ST_DONE);
    res.improved      = improved_r;
    res.popped        = popped_r;
    res.repeat_flag   = repeat_next;
    res.pending_count = pending_next;
    res.bucket_now    = current_next;
    res.dist_out      = dist_o_r;
    res.parent_out    = parent_o_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      seed_pend      <= 1'b0;
      pending        <= '0;
      repeat_bit     <= 1'b0;
      current_bucket <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (item_take) begin
        clr_idx   <= '0;
        seed_pend <= (item_mode == MODE_START);
      end
      if (commit) begin
        pending        <= pending_next;
        repeat_bit     <= repeat_next;
        current_bucket <= current_next;
      end
    end
  end

  // item and per-item flags
  always_ff @(posedge clk) begin
    if (item_take) begin
      mode_r     <= item_mode;
      a_r        <= item_a;
      b_r        <= item_b;
      w_r        <= item_w;
      improved_r <= 1'b0;
      popped_r   <= 1'b0;
      dist_o_r   <= '0;
      parent_o_r <= '0;
    end
    unique case (state)
      ST_RD_B: begin
        nd_r <= {1'b0, mem_rd.path_len} + (DIST_W + 1)'(w_r);
      end
      ST_CMP: begin
        improved_r <= relax_win;
        b_fresh_r  <= (mem_rd.bucket == UNREACHED);
      end
      ST_POP_CHK: begin
        popped_r <= pop_hit;
      end
      ST_QUERY_CAP: begin
        dist_o_r   <= mem_rd.path_len;
        parent_o_r <= mem_rd.parent;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/delta_stepping_relax_engine_top.sv @@
// top level of the delta-stepping relax engine: config port, output register
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | mode, vertex_a, vertex_b, edge_weight
//  out      | out_valid / out_stall| improved, popped, repeat_flag,
//           |                      | pending_count, bucket_now, dist_out,
//           |                      | parent_out
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// one item at a time; the table memory and the bit-serial divider set the pace
// relax reads vertex a, then b, compares, and on a gain waits on the divider before writing b
// start: the table is cleared, one table entry cleared a cycle, then the source is seeded
// after reset a clearing pass over every table entry runs before the first item is taken
// a result waits in the output register while the next item is already taken in
module delta_stepping_relax_engine_top import dsre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            mode,
  input  logic [VERTEX_W-1:0]   vertex_a,
  input  logic [VERTEX_W-1:0]   vertex_b,
  input  logic [WEIGHT_W-1:0]   edge_weight,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  improved,
  output logic                  popped,
  output logic                  repeat_flag,
  output logic [COUNT_W-1:0]    pending_count,
  output logic [DIST_W-1:0]     bucket_now,
  output logic [DIST_W-1:0]     dist_out,
  output logic [PARENT_W-1:0]   parent_out,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [DIST_W-1:0] bucket_width;
  logic              cfg_wr;
  logic              item_take;
  logic              busy;
  logic              res_valid;
  logic              res_take;
  res_t              res;
  mem_req_t          mem_req;
  entry_t            mem_rd;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_width <= DIST_W'(1);
    end else if (cfg_wr && (paddr[2] == REG_BUCKET_WIDTH)) begin
      bucket_width <= pwdata[DIST_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BUCKET_WIDTH) begin
      prdata = 32'(bucket_width);
    end
  end

  // input transfer
  assign in_stall  = busy;
  assign item_take = in_valid && !in_stall;

  // output register takes a result when empty or being drained
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      improved      <= res.improved;
      popped        <= res.popped;
      repeat_flag   <= res.repeat_flag;
      pending_count <= res.pending_count;
      bucket_now    <= res.bucket_now;
      dist_out      <= res.dist_out;
      parent_out    <= res.parent_out;
    end
  end

  dsre_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .item_take (item_take),
    .item_mode (mode_t'(mode)),
    .item_a    (vertex_a),
    .item_b    (vertex_b),
    .item_w    (edge_weight),
    .busy      (busy),
    .mem_req   (mem_req),
    .mem_rd    (mem_rd),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  dsre_table_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  dsre_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .divisor (bucket_width),
    .rsp     (div_rsp)
  );

endmodule

@@ tb/delta_stepping_relax_engine_tb.sv @@
// self-checking testbench of the delta-stepping relax engine with a table-level predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dsre_pkg::*;

  // mode codes the block does not decode
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam logic [CFG_ADDR_W-1:0] BUCKET_WIDTH_ADDR = CFG_ADDR_W'({REG_BUCKET_WIDTH, 2'b00});

  // slowest correct run: ~60 starts, ~800 relaxes, each result stalled at 49 percent,
  // plus the clearing pass; the limit is that run taken fifteen times over
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int TAIL_CYCLES = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            mode = '0;
  logic [VERTEX_W-1:0]   vertex_a = '0;
  logic [VERTEX_W-1:0]   vertex_b = '0;
  logic [WEIGHT_W-1:0]   edge_weight = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  improved;
  logic                  popped;
  logic                  repeat_flag;
  logic [COUNT_W-1:0]    pending_count;
  logic [DIST_W-1:0]     bucket_now;
  logic [DIST_W-1:0]     dist_out;
  logic [PARENT_W-1:0]   parent_out;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  delta_stepping_relax_engine_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .vertex_a(vertex_a),
    .vertex_b(vertex_b), .edge_weight(edge_weight),
    .out_valid(out_valid), .out_stall(out_stall), .improved(improved), .popped(popped),
    .repeat_flag(repeat_flag), .pending_count(pending_count), .bucket_now(bucket_now),
    .dist_out(dist_out), .parent_out(parent_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // predicted engine state
  logic [DIST_W-1:0]   dist_tab   [VERTEX_COUNT];
  logic [PARENT_W-1:0] parent_tab [VERTEX_COUNT];
  logic [DIST_W-1:0]   bucket_tab [VERTEX_COUNT];
  logic [COUNT_W-1:0]  pend_cnt;
  logic [DIST_W-1:0]   cur_bkt;
  logic                rep_bit;
  logic [DIST_W-1:0]   bucket_delta;

  res_t sssp_results_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  int n_items = 0, n_checked = 0, n_starts = 0, n_improved = 0, n_popped = 0, n_writes = 0;

  // vertex pool of the current random graph
  logic [VERTEX_W-1:0] pool [64];
  int pool_n = 1;
  int weight_cap = 15;

  function automatic void clear_tables();
    for (int v = 0; v < VERTEX_COUNT; v++) begin
      dist_tab[v]   = UNREACHED;
      parent_tab[v] = PARENT_NONE;
      bucket_tab[v] = UNREACHED;
    end
    pend_cnt = '0;
    cur_bkt  = '0;
  endfunction

  // apply one item to the predicted tables and return the result it yields
  function automatic res_t predict_sssp_result(input logic [2:0] md,
                                               input logic [VERTEX_W-1:0] a, b,
                                               input logic [WEIGHT_W-1:0] w);
    res_t r;
    logic [DIST_W:0] nd;
    logic [DIST_W-1:0] divisor, bk;
    r = '0;
    case (md)
      MODE_START: begin
        clear_tables();
        dist_tab[a]   = '0;
        parent_tab[a] = PARENT_W'(a);
        bucket_tab[a] = '0;
        pend_cnt      = COUNT_W'(1);
        rep_bit       = 1'b1;
      end
      MODE_RELAX: begin
        // sum held one bit wider so it cannot wrap
        nd = {1'b0, dist_tab[a]} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, w};
        if ({1'b0, dist_tab[b]} > nd) begin
          divisor = (bucket_delta == '0) ? DIST_W'(1) : bucket_delta;
          bk = nd[DIST_W-1:0] / divisor;
          if (bucket_tab[b] == UNREACHED && pend_cnt != PENDING_MAX) pend_cnt++;
          dist_tab[b]   = nd[DIST_W-1:0];
          parent_tab[b] = PARENT_W'(a);
          bucket_tab[b] = bk;
          if (bk == cur_bkt) rep_bit = 1'b1;
          r.improved = 1'b1;
        end
      end
      MODE_POP: begin
        if (bucket_tab[a] != UNREACHED && bucket_tab[a] == cur_bkt) begin
          bucket_tab[a] = UNREACHED;
          if (pend_cnt != '0) pend_cnt--;
          r.popped = 1'b1;
        end
      end
      MODE_CLEAR_REPEAT: rep_bit = 1'b0;
      MODE_NEXT_BUCKET:  cur_bkt = cur_bkt + 1'b1;
      MODE_QUERY: begin
        r.dist_out   = dist_tab[a];
        r.parent_out = parent_tab[a];
      end
      default: ;
    endcase
    r.repeat_flag   = rep_bit;
    r.pending_count = pend_cnt;
    r.bucket_now    = cur_bkt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               sssp_results_due.size());
      $display("delta_stepping_relax_engine_top: mismatch");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (sssp_results_due.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, expected nothing, got pending 0x%0h",
                 $time, pending_count);
      end else begin
        want = sssp_results_due.pop_front();
        n_checked++;
        check_field("improved", 32'(want.improved), 32'(improved));
        check_field("popped", 32'(want.popped), 32'(popped));
        check_field("repeat_flag", 32'(want.repeat_flag), 32'(repeat_flag));
        check_field("pending_count", 32'(want.pending_count), 32'(pending_count));
        check_field("bucket_now", 32'(want.bucket_now), 32'(bucket_now));
        check_field("dist_out", 32'(want.dist_out), 32'(dist_out));
        check_field("parent_out", 32'(want.parent_out), 32'(parent_out));
      end
    end
  end

  // one input transfer; leaves valid high, the next task drives it again
  task automatic send_item(input logic [2:0] md, input logic [VERTEX_W-1:0] a, b,
                           input logic [WEIGHT_W-1:0] w);
    res_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= md;
    vertex_a    <= a;
    vertex_b    <= b;
    edge_weight <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_sssp_result(md, a, b, w);
    sssp_results_due.push_back(r);
    n_items++;
    if (md == MODE_START) n_starts++;
    n_improved += r.improved;
    n_popped   += r.popped;
  endtask

  // hold the sender until every due result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sssp_results_due.size() != 0) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic write_bucket_width(input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BUCKET_WIDTH_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bucket_delta = value[DIST_W-1:0];
    n_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("bucket_width readback", {1'b0, value[DIST_W-1:0]}, readback);
  endtask

  // directed items at the reset bucket width of one
  task automatic test_directed();
    send_item(MODE_QUERY, 10'd0, 10'd0, 16'd0);          // nothing reached yet
    send_item(MODE_QUERY, 10'd1023, 10'd0, 16'd0);
    send_item(MODE_POP, 10'd0, 10'd0, 16'd0);
    send_item(MODE_RELAX, 10'd3, 10'd4, 16'd5);          // unreached source
    send_item(MODE_START, 10'd1023, 10'd0, 16'd0);
    send_item(MODE_RELAX, 10'd1023, 10'd0, 16'd0);       // zero weight, current bucket
    send_item(MODE_RELAX, 10'd1023, 10'd5, 16'hFFFF);    // largest weight
    send_item(MODE_RELAX, 10'd0, 10'd5, 16'hFFFF);       // equal distance, no change
    send_item(MODE_RELAX, 10'd0, 10'd5, 16'hFFFE);       // shorter, no new pending
    send_item(MODE_RELAX, 10'd5, 10'd5, 16'd0);          // self edge
    send_item(MODE_RELAX, 10'd7, 10'd8, 16'd1);
    send_item(MODE_QUERY, 10'd5, 10'd0, 16'd0);
    send_item(MODE_CLEAR_REPEAT, 10'd0, 10'd0, 16'd0);
    send_item(MODE_POP, 10'd1023, 10'd0, 16'd0);
    send_item(MODE_POP, 10'd1023, 10'd0, 16'd0);         // already popped
    send_item(MODE_POP, 10'd5, 10'd0, 16'd0);            // other bucket
    send_item(MODE_NEXT_BUCKET, 10'd0, 10'd0, 16'd0);
    send_item(MODE_RELAX, 10'd0, 10'd9, 16'd1);          // lands in the new bucket
    send_item(MODE_POP, 10'd9, 10'd0, 16'd0);
    send_item(MODE_POP, 10'd0, 10'd0, 16'd0);            // bucket already passed
    send_item(MODE_SPARE_LO, 10'h3FF, 10'h3FF, 16'hFFFF);
    send_item(MODE_SPARE_HI, 10'h2AA, 10'h155, 16'hA5A5);
    send_item(MODE_START, 10'd0, 10'd0, 16'd0);          // restart clears the run
    send_item(MODE_QUERY, 10'd5, 10'd0, 16'd0);
    send_item(MODE_QUERY, 10'd0, 10'd0, 16'd0);
  endtask

  function automatic logic [VERTEX_W-1:0] any_pool_vertex();
    return pool[$urandom_range(pool_n - 1)];
  endfunction

  function automatic logic [VERTEX_W-1:0] reached_pool_vertex();
    logic [VERTEX_W-1:0] v;
    v = any_pool_vertex();
    for (int i = 0; i < 6 && dist_tab[v] == UNREACHED; i++) v = any_pool_vertex();
    return v;
  endfunction

  // a pool vertex sitting in the current bucket if there is one
  function automatic logic [VERTEX_W-1:0] poppable_pool_vertex();
    int ofs;
    logic [VERTEX_W-1:0] v;
    ofs = $urandom_range(pool_n - 1);
    for (int i = 0; i < pool_n; i++) begin
      v = pool[(ofs + i) % pool_n];
      if (bucket_tab[v] != UNREACHED && bucket_tab[v] == cur_bkt) return v;
    end
    return pool[ofs];
  endfunction

  function automatic logic [31:0] pick_bucket_width();
    case ($urandom_range(6))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(64, 2);
      5:       return $urandom_range(70000, 65);
      default: return $urandom;
    endcase
  endfunction

  // one shortest-path run on a small random graph, mostly well-formed steps
  task automatic run_sweep(input int len);
    int sel;
    pool_n = $urandom_range(48, 4);
    for (int i = 0; i < pool_n; i++) pool[i] = VERTEX_W'($urandom_range(1023));
    case ($urandom_range(2))
      0:       weight_cap = 15;
      1:       weight_cap = 255;
      default: weight_cap = 65535;
    endcase
    send_item(MODE_START, pool[0], '0, '0);
    for (int k = 0; k < len; k++) begin
      sel = $urandom_range(99);
      if (sel < 45)
        send_item(MODE_RELAX, reached_pool_vertex(), any_pool_vertex(),
                  WEIGHT_W'($urandom_range(weight_cap)));
      else if (sel < 60)
        send_item(MODE_POP, poppable_pool_vertex(), '0, '0);
      else if (sel < 64)
        send_item(MODE_POP, any_pool_vertex(), '0, '0);
      else if (sel < 74)
        send_item(MODE_QUERY, any_pool_vertex(), '0, '0);
      else if (sel < 82)
        send_item(MODE_NEXT_BUCKET, '0, '0, '0);
      else if (sel < 87)
        send_item(MODE_CLEAR_REPEAT, '0, '0, '0);
      else if (sel < 89)
        send_item(MODE_START, any_pool_vertex(), '0, '0);
      else
        // noise over the full field ranges
        send_item(3'($urandom_range(7)), VERTEX_W'($urandom_range(1023)),
                  VERTEX_W'($urandom_range(1023)), WEIGHT_W'($urandom_range(65535)));
    end
  endtask

  task automatic test_random_phase(input int n, input int send_pct, input int recv_pct);
    int sent;
    int len;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n) begin
      drain_results();
      write_bucket_width(pick_bucket_width());
      len = $urandom_range(140, 40);
      run_sweep(len);
      sent += len + 1;
    end
  endtask

  initial begin
    rep_bit = 1'b0;
    bucket_delta = DIST_W'(1);
    clear_tables();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    drain_results();
    write_bucket_width(32'd0);
    write_bucket_width(32'hFFFF_FFFF);
    test_random_phase(530, 8, 49);
    test_random_phase(530, 49, 8);
    test_random_phase(530, 0, 0);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d run starts, %0d shortened edges, %0d pops), %0d results",
             n_items, n_starts, n_improved, n_popped, n_checked);
    $display("bucket width written %0d times, zero and full range among the settings",
             n_writes);
    if (errors == 0) begin
      $display("delta_stepping_relax_engine_top: match");
    end else begin
      $display("delta_stepping_relax_engine_top: mismatch");
    end
    $finish;
  end

endmodule
